>>> hw/rtl/cpd_pkg.sv
// cpd_pkg: shared types, constants and the burst classifier for the coin pulse decoder.
// No dependencies; used by every module under hw/rtl.
`timescale 1ns / 1ps
`default_nettype none

package cpd_pkg;

    localparam int TIME_W  = 32;
    localparam int CFG_W   = 16;
    localparam int TALLY_W = 6;
    localparam int TOTAL_W = 24;
    localparam int VALUE_W = 4;

    localparam logic [TALLY_W-1:0] TALLY_MAX = '1;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    // opcodes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [1:0] REG_MIN_PULSE = 2'd1;
    localparam logic [1:0] REG_TIMEOUT  = 2'd2;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST  = 16'd10;
    localparam logic [CFG_W-1:0] MIN_PULSE_RST = 16'd15;
    localparam logic [CFG_W-1:0] TIMEOUT_RST   = 16'd150;

    localparam logic [VALUE_W-1:0] VALUE_NONE = 4'd0;
    localparam logic [VALUE_W-1:0] VALUE_ONE  = 4'd1;
    localparam logic [VALUE_W-1:0] VALUE_FIVE = 4'd5;
    localparam logic [VALUE_W-1:0] VALUE_TEN  = 4'd10;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_ms;
        logic [CFG_W-1:0] min_pulse_ms;
        logic [CFG_W-1:0] burst_timeout_ms;
    } t_cfg;

    typedef struct packed {
        logic              opcode;
        logic              line_level;
        logic [TIME_W-1:0] now_ms;
    } t_item;

    typedef struct packed {
        logic [VALUE_W-1:0] credited_value;
        logic               burst_rejected;
        logic [TOTAL_W-1:0] running_total;
    } t_result;

    // pulse count -> coin value; zero means the burst is rejected
    function automatic logic [VALUE_W-1:0] burst_value(input logic [TALLY_W-1:0] n);
        logic [VALUE_W-1:0] v;
        v = VALUE_NONE;
        if (n >= 6'd1 && n <= 6'd3) begin
            v = VALUE_ONE;
        end else if (n >= 6'd5 && n <= 6'd7) begin
            v = VALUE_FIVE;
        end else if (n >= 6'd10 && n <= 6'd14) begin
            v = VALUE_TEN;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/cpd_cfg_regs.sv
// cpd_cfg_regs: APB-style register file for debounce, minimum pulse and burst timeout.
// Depends on cpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cpd_cfg_regs (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [3:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output cpd_pkg::t_cfg      o_cfg
);

    cpd_pkg::t_cfg r_cfg;
    logic          wr_en;
    logic [1:0]    reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms      <= cpd_pkg::DEBOUNCE_RST;
            r_cfg.min_pulse_ms     <= cpd_pkg::MIN_PULSE_RST;
            r_cfg.burst_timeout_ms <= cpd_pkg::TIMEOUT_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                cpd_pkg::REG_DEBOUNCE:  r_cfg.debounce_ms      <= pwdata[cpd_pkg::CFG_W-1:0];
                cpd_pkg::REG_MIN_PULSE: r_cfg.min_pulse_ms     <= pwdata[cpd_pkg::CFG_W-1:0];
                cpd_pkg::REG_TIMEOUT:   r_cfg.burst_timeout_ms <= pwdata[cpd_pkg::CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            cpd_pkg::REG_DEBOUNCE:  prdata = {16'd0, r_cfg.debounce_ms};
            cpd_pkg::REG_MIN_PULSE: prdata = {16'd0, r_cfg.min_pulse_ms};
            cpd_pkg::REG_TIMEOUT:   prdata = {16'd0, r_cfg.burst_timeout_ms};
            default:                prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

>>> hw/rtl/cpd_step.sv
// cpd_step: edge detection, pulse timing, burst classification and credit state.
// Depends on cpd_pkg. State advances once per word when i_step is high.
`timescale 1ns / 1ps
`default_nettype none

module cpd_step (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_step,
    input  wire cpd_pkg::t_item  i_item,
    input  wire cpd_pkg::t_cfg   i_cfg,
    output cpd_pkg::t_result     o_res
);

    logic                           r_prev_level, n_prev_level;
    logic [cpd_pkg::TIME_W-1:0]     r_low_start, n_low_start;
    logic [cpd_pkg::TIME_W-1:0]     r_last_edge, n_last_edge;
    logic [cpd_pkg::TIME_W-1:0]     r_last_pulse, n_last_pulse;
    logic [cpd_pkg::TALLY_W-1:0]    r_tally, n_tally;
    logic [cpd_pkg::TOTAL_W-1:0]    r_total, n_total;

    logic                           fall, rise, counted, burst_end;
    logic [cpd_pkg::TIME_W-1:0]     gap_edge, gap_low, gap_pulse;
    logic [cpd_pkg::TALLY_W-1:0]    tally_upd;
    logic [cpd_pkg::VALUE_W-1:0]    value;
    logic [cpd_pkg::TOTAL_W:0]      sum;

    always_comb begin
        fall      = r_prev_level && !i_item.line_level;
        rise      = !r_prev_level && i_item.line_level;
        gap_edge  = i_item.now_ms - r_last_edge;
        gap_low   = i_item.now_ms - r_low_start;
        gap_pulse = i_item.now_ms - r_last_pulse;
        counted   = rise && (gap_low >= {16'd0, i_cfg.min_pulse_ms});

        tally_upd = r_tally;
        if (counted && r_tally != cpd_pkg::TALLY_MAX) begin
            tally_upd = r_tally + 6'd1;
        end

        // a pulse counted this word leaves zero quiet time, so no burst end
        burst_end = !counted && (tally_upd != '0)
                    && (gap_pulse > {16'd0, i_cfg.burst_timeout_ms});
        value     = cpd_pkg::burst_value(tally_upd);
        sum       = {1'b0, r_total} + {{(cpd_pkg::TOTAL_W+1-cpd_pkg::VALUE_W){1'b0}}, value};

        n_prev_level = r_prev_level;
        n_low_start  = r_low_start;
        n_last_edge  = r_last_edge;
        n_last_pulse = r_last_pulse;
        n_tally      = r_tally;
        n_total      = r_total;
        o_res.credited_value = cpd_pkg::VALUE_NONE;
        o_res.burst_rejected = 1'b0;

        unique case (i_item.opcode)
            cpd_pkg::OP_CLEAR: begin
                n_total = '0;
            end
            cpd_pkg::OP_SAMPLE: begin
                n_prev_level = i_item.line_level;
                if (fall) begin
                    if (gap_edge > {16'd0, i_cfg.debounce_ms}) begin
                        n_low_start = i_item.now_ms;
                    end
                    n_last_edge = i_item.now_ms;
                end
                if (rise) begin
                    n_last_edge = i_item.now_ms;
                end
                if (counted) begin
                    n_last_pulse = i_item.now_ms;
                end
                n_tally = tally_upd;
                if (burst_end) begin
                    n_tally = '0;
                    o_res.credited_value = value;
                    if (value != cpd_pkg::VALUE_NONE) begin
                        n_total = sum[cpd_pkg::TOTAL_W] ? cpd_pkg::TOTAL_MAX
                                                       : sum[cpd_pkg::TOTAL_W-1:0];
                    end else begin
                        o_res.burst_rejected = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        o_res.running_total = n_total;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_level <= 1'b1;
            r_low_start  <= '0;
            r_last_edge  <= '0;
            r_last_pulse <= '0;
            r_tally      <= '0;
            r_total      <= '0;
        end else if (i_step) begin
            r_prev_level <= n_prev_level;
            r_low_start  <= n_low_start;
            r_last_edge  <= n_last_edge;
            r_last_pulse <= n_last_pulse;
            r_tally      <= n_tally;
            r_total      <= n_total;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/coin_pulse_decoder.sv
// coin_pulse_decoder: top level; input word register, step logic, result register.
// Depends on cpd_pkg, cpd_cfg_regs and cpd_step.
//
//   channel  | handshake                   | payload
//   ---------+-----------------------------+-----------------------------------------
//   input    | i_in_valid / o_in_stall     | i_opcode, i_line_level, i_now_ms
//   output   | o_out_valid / i_out_stall   | o_credited_value, o_burst_rejected,
//            |                             | o_running_total
//   config   | psel/penable/pwrite, pready | paddr, pwdata, prdata
//
// One word per cycle while the output is not stalled.
// The step logic sits between the input register and the result register.
// A stalled result holds; the input stalls only while both registers are full.
// Synchronous active-low reset clears handshake state, decoder state and config registers.
`timescale 1ns / 1ps
`default_nettype none

module coin_pulse_decoder (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    input  wire logic           i_opcode,
    input  wire logic           i_line_level,
    input  wire logic [31:0]    i_now_ms,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output logic [3:0]          o_credited_value,
    output logic                o_burst_rejected,
    output logic [23:0]         o_running_total,
    input  wire logic           psel,
    input  wire logic           penable,
    input  wire logic           pwrite,
    input  wire logic [3:0]     paddr,
    input  wire logic [31:0]    pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    cpd_pkg::t_cfg    cfg;
    cpd_pkg::t_item   r_item;
    cpd_pkg::t_result step_res, r_res;
    logic             r_in_valid, r_out_valid;
    logic             step, in_load;

    // item leaves the input register when the result slot is free or draining
    assign step       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !step;
    assign in_load    = i_in_valid && !o_in_stall;

    cpd_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    cpd_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_item  (r_item),
        .i_cfg   (cfg),
        .o_res   (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_load) begin
                r_in_valid <= 1'b1;
            end else if (step) begin
                r_in_valid <= 1'b0;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_item.opcode     <= i_opcode;
            r_item.line_level <= i_line_level;
            r_item.now_ms     <= i_now_ms;
        end
        if (step) begin
            r_res <= step_res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_credited_value = r_res.credited_value;
    assign o_burst_rejected = r_res.burst_rejected;
    assign o_running_total  = r_res.running_total;

endmodule

`default_nettype wire

>>> tb/cpd_checker.sv
// cpd_checker: watches the input, output and register ports of coin_pulse_decoder,
// predicts one result per accepted input word and compares them in order.
// Depends on cpd_pkg for the word, result and config types and constants.
`timescale 1ns / 1ps

module cpd_checker
    import cpd_pkg::*;
(
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire logic           i_in_stall,
    input  wire logic           i_opcode,
    input  wire logic           i_line_level,
    input  wire logic [31:0]    i_now_ms,
    input  wire logic           i_out_valid,
    input  wire logic           i_out_stall,
    input  wire logic [3:0]     i_credited_value,
    input  wire logic           i_burst_rejected,
    input  wire logic [23:0]    i_running_total,
    input  wire logic           psel,
    input  wire logic           penable,
    input  wire logic           pwrite,
    input  wire logic           pready,
    input  wire logic [3:0]     paddr,
    input  wire logic [31:0]    pwdata,
    output int                  o_fails,
    output int                  o_pending,
    output int                  o_checked,
    output int                  o_credits,
    output int                  o_rejects
);

    t_cfg               cfg;
    logic               level_q;
    logic [TIME_W-1:0]  low_start_ms;
    logic [TIME_W-1:0]  last_edge_ms;
    logic [TIME_W-1:0]  last_pulse_ms;
    logic [TALLY_W-1:0] tally;
    logic [TOTAL_W-1:0] total;

    t_result expected_results[$];
    int      fails;
    int      checked;
    int      credits;
    int      rejects;

    function automatic logic [VALUE_W-1:0] coin_value(input logic [TALLY_W-1:0] n);
        logic [VALUE_W-1:0] v;
        case (n)
            6'd1, 6'd2, 6'd3:                   v = VALUE_ONE;
            6'd5, 6'd6, 6'd7:                   v = VALUE_FIVE;
            6'd10, 6'd11, 6'd12, 6'd13, 6'd14:  v = VALUE_TEN;
            default:                            v = VALUE_NONE;
        endcase
        return v;
    endfunction

    // advances the decoder state by one word and returns the result it causes
    function automatic t_result decode_word(input t_item w);
        t_result            r;
        logic [TIME_W-1:0]  span;
        logic [VALUE_W-1:0] v;
        logic [TOTAL_W:0]   sum;
        r.credited_value = VALUE_NONE;
        r.burst_rejected = 1'b0;
        if (w.opcode == OP_CLEAR) begin
            total = '0;
        end else begin
            if (level_q && !w.line_level) begin
                span = w.now_ms - last_edge_ms;
                if (span > {16'd0, cfg.debounce_ms}) begin
                    low_start_ms = w.now_ms;
                end
                last_edge_ms = w.now_ms;
            end
            if (!level_q && w.line_level) begin
                span = w.now_ms - low_start_ms;
                if (span >= {16'd0, cfg.min_pulse_ms}) begin
                    if (tally != TALLY_MAX) begin
                        tally = tally + 1'b1;
                    end
                    last_pulse_ms = w.now_ms;
                end
                // short pulses still move the edge time
                last_edge_ms = w.now_ms;
            end
            level_q = w.line_level;
            span = w.now_ms - last_pulse_ms;
            if (tally != '0 && span > {16'd0, cfg.burst_timeout_ms}) begin
                v = coin_value(tally);
                if (v != VALUE_NONE) begin
                    sum = {1'b0, total} + {{(TOTAL_W+1-VALUE_W){1'b0}}, v};
                    total = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
                    r.credited_value = v;
                    credits++;
                end else begin
                    r.burst_rejected = 1'b1;
                    rejects++;
                end
                tally = '0;
            end
        end
        r.running_total = total;
        return r;
    endfunction

    task automatic flag_failure(input string msg);
        fails++;
        if (fails <= 10) begin
            $display("%0t: %s", $time, msg);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_item   w;
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            cfg.debounce_ms      = DEBOUNCE_RST;
            cfg.min_pulse_ms     = MIN_PULSE_RST;
            cfg.burst_timeout_ms = TIMEOUT_RST;
            level_q       = 1'b1;
            low_start_ms  = '0;
            last_edge_ms  = '0;
            last_pulse_ms = '0;
            tally         = '0;
            total         = '0;
            expected_results.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_DEBOUNCE:  cfg.debounce_ms      = pwdata[CFG_W-1:0];
                    REG_MIN_PULSE: cfg.min_pulse_ms     = pwdata[CFG_W-1:0];
                    REG_TIMEOUT:   cfg.burst_timeout_ms = pwdata[CFG_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                got.credited_value = i_credited_value;
                got.burst_rejected = i_burst_rejected;
                got.running_total  = i_running_total;
                if (expected_results.size() == 0) begin
                    flag_failure($sformatf("unexpected result: value=%0d rej=%0d total=%0d",
                                           got.credited_value, got.burst_rejected,
                                           got.running_total));
                end else begin
                    want = expected_results.pop_front();
                    checked++;
                    if (got.credited_value != want.credited_value ||
                        got.burst_rejected != want.burst_rejected ||
                        got.running_total != want.running_total) begin
                        flag_failure($sformatf({"mismatch: expected value=%0d rej=%0d ",
                                                "total=%0d, got value=%0d rej=%0d total=%0d"},
                                               want.credited_value, want.burst_rejected,
                                               want.running_total, got.credited_value,
                                               got.burst_rejected, got.running_total));
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                w.opcode     = i_opcode;
                w.line_level = i_line_level;
                w.now_ms     = i_now_ms;
                expected_results.push_back(decode_word(w));
            end
        end
        o_fails   <= fails;
        o_pending <= expected_results.size();
        o_checked <= checked;
        o_credits <= credits;
        o_rejects <= rejects;
    end

endmodule

>>> tb/tb_top.sv
// tb_top: stimulus and verdict for coin_pulse_decoder; coin bursts, line chatter,
// clears and register changes, with random idling on both channels.
// Depends on cpd_pkg, coin_pulse_decoder and cpd_checker.
`timescale 1ns / 1ps

module tb_top;
    import cpd_pkg::*;

    localparam int         LIMIT      = 500000;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic        opcode     = OP_SAMPLE;
    logic        line_level = 1'b1;
    logic [31:0] now_ms     = '0;
    logic        out_stall  = 1'b0;
    logic        psel       = 1'b0;
    logic        penable    = 1'b0;
    logic        pwrite     = 1'b0;
    logic [3:0]  paddr      = '0;
    logic [31:0] pwdata     = '0;

    wire logic        in_stall;
    wire logic        out_valid;
    wire logic [3:0]  credited_value;
    wire logic        burst_rejected;
    wire logic [23:0] running_total;
    wire logic [31:0] prdata;
    wire logic        pready;

    int fails, pending, checked, credits, rejects;

    logic [31:0] clock_ms = '0;
    int          words_sent = 0;
    int          cfg_deb = DEBOUNCE_RST;
    int          cfg_min = MIN_PULSE_RST;
    int          cfg_tmo = TIMEOUT_RST;
    bit          idle_on = 1'b1;
    int          hold_asked = 0;
    int          hold_done = 0;
    int          cycles = 0;

    coin_pulse_decoder uut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_opcode         (opcode),
        .i_line_level     (line_level),
        .i_now_ms         (now_ms),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_credited_value (credited_value),
        .o_burst_rejected (burst_rejected),
        .o_running_total  (running_total),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    cpd_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_opcode         (opcode),
        .i_line_level     (line_level),
        .i_now_ms         (now_ms),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_credited_value (credited_value),
        .i_burst_rejected (burst_rejected),
        .i_running_total  (running_total),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .pready           (pready),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .o_fails          (fails),
        .o_pending        (pending),
        .o_checked        (checked),
        .o_credits        (credits),
        .o_rejects        (rejects)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin : watchdog
        while (cycles < LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("watchdog: no finish after %0d cycles", LIMIT);
        $display("** coin_pulse_decoder: FAILED **");
        $finish;
    end

    // result side: random stall bursts, plus a long hold when the stimulus asks for one
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge clk);
            if (hold_asked != hold_done) begin
                hold_done++;
                stall_left = 80;
            end else if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 9);
            end
            if (stall_left > 0) begin
                out_stall <= 1'b1;
                stall_left--;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    task automatic put_word(input logic op, input logic lvl, input logic [31:0] stamp);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        opcode     <= op;
        line_level <= lvl;
        now_ms     <= stamp;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        words_sent++;
    endtask

    task automatic sample(input logic lvl, input int unsigned delta);
        clock_ms = clock_ms + delta;
        put_word(OP_SAMPLE, lvl, clock_ms);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        logic [15:0] junk;
        junk = 16'($urandom);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {junk, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input int deb, input int minp, input int tmo);
        drain_results();
        repeat (4) @(posedge clk);
        write_reg(REG_DEBOUNCE, deb[15:0]);
        write_reg(REG_MIN_PULSE, minp[15:0]);
        write_reg(REG_TIMEOUT, tmo[15:0]);
        cfg_deb = deb;
        cfg_min = minp;
        cfg_tmo = tmo;
    endtask

    // a burst of coin pulses with jittered gaps and widths, then a quiet stretch
    task automatic coin_burst(input int pulses);
        int gap, width, half;
        for (int k = 0; k < pulses; k++) begin
            if ($urandom_range(0, 9) == 0) begin
                gap = $urandom_range(0, cfg_deb);
            end else begin
                gap = cfg_deb + 1 + $urandom_range(0, 4 + cfg_deb / 2);
            end
            if ($urandom_range(0, 7) == 0) begin
                width = $urandom_range(0, cfg_min);
            end else begin
                width = cfg_min + $urandom_range(0, 3 + cfg_min / 4);
            end
            sample(1'b0, gap);
            if ($urandom_range(0, 9) == 0) begin
                // contact bounce right after the fall
                sample(1'b1, 1);
                sample(1'b0, 1);
            end
            if ($urandom_range(0, 2) == 0) begin
                half = width / 2;
                sample(1'b0, half);
                sample(1'b1, width - half);
            end else begin
                sample(1'b1, width);
            end
        end
        if ($urandom_range(0, 3) == 0) begin
            sample(1'b1, cfg_tmo);
        end
        sample(1'b1, cfg_tmo + 1 + $urandom_range(0, 20));
    endtask

    task automatic random_traffic(input int upto);
        int pick;
        while (words_sent < upto) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                if ($urandom_range(0, 9) < 8) begin
                    coin_burst($urandom_range(1, 15));
                end else begin
                    coin_burst($urandom_range(16, 24));
                end
            end else if (pick < 80) begin
                repeat ($urandom_range(1, 4)) begin
                    clock_ms = $urandom;
                    put_word(($urandom_range(0, 3) == 0) ? OP_CLEAR : OP_SAMPLE,
                             1'($urandom_range(0, 1)), clock_ms);
                end
            end else if (pick < 86) begin
                put_word(OP_CLEAR, 1'($urandom_range(0, 1)),
                         clock_ms + $urandom_range(0, 50));
            end else if (pick < 90) begin
                drain_results();
            end else begin
                // line chatter in small steps
                repeat ($urandom_range(2, 8)) begin
                    sample(1'($urandom_range(0, 1)), $urandom_range(0, 3));
                end
            end
        end
    endtask

    initial begin : stimulus
        int deb, minp;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: single coin, bounce inside debounce, four-pulse reject, wrap
        put_word(OP_SAMPLE, 1'b1, 32'd0);
        put_word(OP_CLEAR, 1'b0, 32'hFFFF_FFFF);
        put_word(OP_SAMPLE, 1'b0, 32'd100);
        put_word(OP_SAMPLE, 1'b1, 32'd120);
        put_word(OP_SAMPLE, 1'b1, 32'd300);
        put_word(OP_SAMPLE, 1'b0, 32'd400);
        put_word(OP_SAMPLE, 1'b1, 32'd405);
        put_word(OP_SAMPLE, 1'b0, 32'd410);
        put_word(OP_SAMPLE, 1'b1, 32'd430);
        put_word(OP_SAMPLE, 1'b1, 32'd600);
        for (int p = 0; p < 4; p++) begin
            put_word(OP_SAMPLE, 1'b0, 32'd700 + 40 * p);
            put_word(OP_SAMPLE, 1'b1, 32'd720 + 40 * p);
        end
        put_word(OP_SAMPLE, 1'b1, 32'd1000);
        put_word(OP_CLEAR, 1'b1, 32'd1001);
        put_word(OP_SAMPLE, 1'b0, 32'hFFFF_FFF0);
        put_word(OP_SAMPLE, 1'b1, 32'h0000_0010);
        put_word(OP_SAMPLE, 1'b1, 32'hFFFF_FFFF);
        clock_ms = 32'd2000;

        set_config(3, 8, 40);
        hold_asked++;
        coin_burst(12);
        coin_burst(90);
        random_traffic(350);

        set_config(0, 0, 0);
        random_traffic(480);

        set_config(65535, 65535, 65535);
        clock_ms = 32'hFFFF_0000;
        random_traffic(620);

        deb  = $urandom_range(0, 20);
        minp = $urandom_range(1, 40);
        set_config(deb, minp, deb + minp + $urandom_range(20, 200));
        write_reg(REG_UNUSED, 16'hFFFF);
        random_traffic(1100);

        idle_on = 1'b0;
        random_traffic(1350);

        drain_results();
        repeat (8) @(posedge clk);
        $display("coin_pulse_decoder: %0d words, %0d results checked, %0d credits, %0d rejects",
                 words_sent, checked, credits, rejects);
        $display("covered reset, small, all-zero, all-max and random settings, wrapped time");
        if (fails == 0) begin
            $display("** coin_pulse_decoder: PASSED **");
        end else begin
            $display("** coin_pulse_decoder: FAILED **");
        end
        $finish;
    end

endmodule
